[design/rpd_pkg.sv]
// Package for the readout packet deframer: item and result structs,
// format and error codes, flag bit positions. No dependencies.
`default_nettype none

package rpd_pkg;

    localparam int MAX_WORDS_DEF = 1024;
    localparam int HEADER_WORDS  = 5;
    localparam int FOOTER_WORDS  = 1;

    localparam int WORD_W  = 32;
    localparam int FIELD_W = 16;

    // Packet word flag bits
    localparam int END_BIT   = 31;
    localparam int BEGIN_BIT = 30;
    localparam int HDR_BIT   = 29;

    localparam logic [15:0] FMT_A_NUMBER  = 16'd791;
    localparam logic [15:0] FMT_B1_NUMBER = 16'd1291;
    localparam logic [15:0] FMT_B2_NUMBER = 16'd1391;

    // Words since the begin word saturate here
    localparam logic [3:0] SINCE_BEGIN_SAT = 4'd8;
    localparam logic [3:0] HEADER_LEN      = 4'(HEADER_WORDS);
    localparam logic [3:0] SHORT_LIMIT     = 4'(HEADER_WORDS + FOOTER_WORDS - 1);
    localparam logic [2:0] HDR_COUNT_SAT   = 3'd7;
    localparam logic [2:0] HDR_COUNT_GOOD  = 3'(HEADER_WORDS);

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        FMT_UNKNOWN = 2'd0,
        FMT_A       = 2'd1,
        FMT_B       = 2'd2
    } fmt_t;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_BAD_FORMAT    = 3'd1,
        ERR_TOO_LONG      = 3'd2,
        ERR_NO_BEGIN      = 3'd3,
        ERR_NO_END        = 3'd4,
        ERR_END_MISPLACED = 3'd5,
        ERR_HDR_MISMATCH  = 3'd6,
        ERR_TOO_SHORT     = 3'd7
    } err_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [15:0]        format_number;
        logic               last_word;
    } item_t;

    typedef struct packed {
        logic               kind;
        logic [WORD_W-1:0]  data_word;
        logic [FIELD_W-1:0] event_number;
        logic [FIELD_W-1:0] flag_word;
        logic [FIELD_W-1:0] detector_id;
        logic [FIELD_W-1:0] module_address;
        logic [FIELD_W-1:0] clock_counter;
        logic               parity_ok;
        logic [3:0]         packet_word_count;
        logic [FIELD_W-1:0] parity_word;
        logic [2:0]         error_code;
        logic               end_of_packet;
    } result_t;

    function automatic fmt_t decode_format(input logic [15:0] num);
        fmt_t f;
        f = FMT_UNKNOWN;
        if (num == FMT_A_NUMBER) begin
            f = FMT_A;
        end else if (num == FMT_B1_NUMBER || num == FMT_B2_NUMBER) begin
            f = FMT_B;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

[design/readout_packet_deframer_top.sv]
// Readout packet deframer: splits packet words into data words and a
// closing summary. Depends on rpd_pkg, rpd_in_stage, rpd_decoder,
// rpd_out_stage.
//
// Usage: feed one 32-bit packet word per s_ handshake, with the packet's
// format number (sampled on its first word) and s_last_word on the footer.
// Each word after the five header words, except the footer, comes out on
// the m_ channel as a data word (m_kind = 0). The footer produces one
// summary word (m_kind = 1, m_end_of_packet = 1) carrying the header
// fields and parity, or a nonzero m_error_code; drop the packet's data
// words when an error summary follows. Header words produce nothing.
// Path to m_valid: the accepted word sits in the input register, passes
// one decode pass and lands in the result register. Throughput is one
// word per cycle while the receiver does not stall, set by the single
// decode pass between the two registers.
// When the receiver stalls, the result register holds its word and s_ready
// drops once the input register holds a word (an empty one takes one more).
// Reset (aresetn low, synchronous) empties both registers and clears all
// packet tracking state; the next word starts a new packet.
`default_nettype none

module readout_packet_deframer_top #(
    parameter int MAX_WORDS = rpd_pkg::MAX_WORDS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [31:0]   s_word,
    input  wire logic [15:0]   s_format_number,
    input  wire logic          s_last_word,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_kind,
    output logic [31:0]        m_data_word,
    output logic [15:0]        m_event_number,
    output logic [15:0]        m_flag_word,
    output logic [15:0]        m_detector_id,
    output logic [15:0]        m_module_address,
    output logic [15:0]        m_clock_counter,
    output logic               m_parity_ok,
    output logic [3:0]         m_packet_word_count,
    output logic [15:0]        m_parity_word,
    output logic [2:0]         m_error_code,
    output logic               m_end_of_packet
);
    import rpd_pkg::*;

    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    fire;
    result_t result;
    logic    has_result;
    result_t m_result;

    // advance a word only when the result register can take its output
    assign fire = item_valid && out_free;

    rpd_in_stage u_in_stage (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_word          (s_word),
        .s_format_number (s_format_number),
        .s_last_word     (s_last_word),
        .item            (item),
        .item_valid      (item_valid),
        .item_take       (fire)
    );

    rpd_decoder #(
        .MAX_WORDS (MAX_WORDS)
    ) u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (item),
        .fire       (fire),
        .result     (result),
        .has_result (has_result)
    );

    rpd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .load     (fire && has_result),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_kind              = m_result.kind;
    assign m_data_word         = m_result.data_word;
    assign m_event_number      = m_result.event_number;
    assign m_flag_word         = m_result.flag_word;
    assign m_detector_id       = m_result.detector_id;
    assign m_module_address    = m_result.module_address;
    assign m_clock_counter     = m_result.clock_counter;
    assign m_parity_ok         = m_result.parity_ok;
    assign m_packet_word_count = m_result.packet_word_count;
    assign m_parity_word       = m_result.parity_word;
    assign m_error_code        = m_result.error_code;
    assign m_end_of_packet     = m_result.end_of_packet;

endmodule

`default_nettype wire

[design/rpd_in_stage.sv]
// Input register of the readout packet deframer: holds one word for the
// decoder. Depends on rpd_pkg.
`default_nettype none

module rpd_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [31:0]   s_word,
    input  wire logic [15:0]   s_format_number,
    input  wire logic          s_last_word,
    output rpd_pkg::item_t     item,
    output logic               item_valid,
    input  wire logic          item_take
);
    import rpd_pkg::*;

    item_t item_reg;
    logic  valid_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.word          <= s_word;
            item_reg.format_number <= s_format_number;
            item_reg.last_word     <= s_last_word;
        end
    end

endmodule

`default_nettype wire

[design/rpd_decoder.sv]
// Packet tracking state and single-pass decode of one word into a data
// word or a packet summary. Depends on rpd_pkg.
`default_nettype none

module rpd_decoder #(
    parameter int MAX_WORDS = rpd_pkg::MAX_WORDS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rpd_pkg::item_t item,
    input  wire logic          fire,
    output rpd_pkg::result_t   result,
    output logic               has_result
);
    import rpd_pkg::*;

    localparam int WC_W = $clog2(MAX_WORDS + 2);
    localparam logic [WC_W-1:0] WC_MAX = WC_W'(MAX_WORDS);

    logic [WC_W-1:0]    wc_reg, wc_next;
    fmt_t               fmt_reg, fmt_next;
    logic               begin_reg, begin_next;
    logic [3:0]         since_reg, since_next;
    logic [2:0]         hc_reg, hc_next;
    logic               closed_reg, closed_next;
    logic               end_seen_reg, end_seen_next;
    logic [15:0]        di_reg, di_next;
    logic [FIELD_W-1:0] hdr_reg [HEADER_WORDS];

    logic       is_end;
    logic       begun;
    logic [3:0] offs;
    logic       hdr_we;
    logic       emit_data;
    err_t       err;

    always_comb begin
        wc_next       = wc_reg;
        fmt_next      = fmt_reg;
        begin_next    = begin_reg;
        since_next    = since_reg;
        hc_next       = hc_reg;
        closed_next   = closed_reg;
        end_seen_next = end_seen_reg;
        di_next       = di_reg;
        result        = '0;
        has_result    = 1'b0;
        err           = ERR_NONE;

        is_end = item.word[END_BIT];
        if (wc_reg == '0) begin
            fmt_next = decode_format(item.format_number);
        end
        if (wc_reg <= WC_MAX) begin
            wc_next = wc_reg + 1'b1;
        end
        if (is_end) begin
            end_seen_next = 1'b1;
        end

        begun = begin_reg || item.word[BEGIN_BIT];
        offs  = begin_reg ? since_reg : 4'd0;
        begin_next = begun;

        hdr_we    = begun && (offs < HEADER_LEN);
        emit_data = begun && (offs >= HEADER_LEN) && !item.last_word
                    && (fmt_next != FMT_UNKNOWN);

        if (begun && !closed_reg) begin
            if (item.word[HDR_BIT]) begin
                if (hc_reg < HDR_COUNT_SAT) begin
                    hc_next = hc_reg + 1'b1;
                end
            end else begin
                closed_next = 1'b1;
            end
        end

        if (emit_data) begin
            has_result       = 1'b1;
            result.kind      = KIND_DATA;
            result.data_word = item.word;
            if (fmt_next == FMT_A) begin
                result.data_word = {di_reg, item.word[15:0]};
                di_next          = di_reg + 1'b1;
            end
            // hold the offset: it stays past the header from here on
            since_next = offs;
        end else if (begun) begin
            since_next = (offs < SINCE_BEGIN_SAT) ? offs + 1'b1 : offs;
        end

        if (item.last_word) begin
            if (fmt_next == FMT_UNKNOWN) begin
                err = ERR_BAD_FORMAT;
            end else if (wc_next > WC_MAX) begin
                err = ERR_TOO_LONG;
            end else if (!begun) begin
                err = ERR_NO_BEGIN;
            end else if (fmt_next == FMT_A && !is_end) begin
                err = end_seen_reg ? ERR_END_MISPLACED : ERR_NO_END;
            end else if (fmt_next == FMT_B && !end_seen_next) begin
                err = ERR_NO_END;
            end else if (fmt_next == FMT_B && hc_next != HDR_COUNT_GOOD) begin
                err = ERR_HDR_MISMATCH;
            end else if (offs < SHORT_LIMIT) begin
                err = ERR_TOO_SHORT;
            end

            has_result           = 1'b1;
            result.kind          = KIND_SUMMARY;
            result.error_code    = err;
            result.end_of_packet = 1'b1;
            if (err == ERR_NONE) begin
                result.event_number   = hdr_reg[0];
                result.flag_word      = hdr_reg[1];
                result.detector_id    = hdr_reg[2];
                result.module_address = hdr_reg[3];
                result.clock_counter  = hdr_reg[4];
                if (fmt_next == FMT_A) begin
                    result.parity_ok   = 1'b1;
                    result.parity_word = item.word[15:0];
                end else begin
                    result.parity_ok         = item.word[0];
                    result.packet_word_count = item.word[11:8];
                    result.parity_word       = item.word[27:12];
                end
            end

            // drop all packet state after the footer
            wc_next       = '0;
            fmt_next      = FMT_UNKNOWN;
            begin_next    = 1'b0;
            since_next    = '0;
            hc_next       = '0;
            closed_next   = 1'b0;
            end_seen_next = 1'b0;
            di_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg       <= '0;
            fmt_reg      <= FMT_UNKNOWN;
            begin_reg    <= 1'b0;
            since_reg    <= '0;
            hc_reg       <= '0;
            closed_reg   <= 1'b0;
            end_seen_reg <= 1'b0;
            di_reg       <= '0;
        end else if (fire) begin
            wc_reg       <= wc_next;
            fmt_reg      <= fmt_next;
            begin_reg    <= begin_next;
            since_reg    <= since_next;
            hc_reg       <= hc_next;
            closed_reg   <= closed_next;
            end_seen_reg <= end_seen_next;
            di_reg       <= di_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && hdr_we) begin
            hdr_reg[offs[2:0]] <= item.word[15:0];
        end
    end

endmodule

`default_nettype wire

[design/rpd_out_stage.sv]
// Result register of the readout packet deframer: holds one result word
// until the receiver takes it. Depends on rpd_pkg.
`default_nettype none

module rpd_out_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rpd_pkg::result_t result,
    input  wire logic          load,
    output logic               free,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rpd_pkg::result_t   m_result
);
    import rpd_pkg::*;

    result_t res_reg;
    logic    valid_reg;

    assign free     = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

endmodule

`default_nettype wire
